FILE: hdl/ndd_pkg.sv
// Shared constants and types for the Newton divided-difference interpolator.
// No dependencies.
`default_nettype none
package ndd_pkg;
    localparam int MaxNodes = 16;
    localparam int IdxW = $clog2(MaxNodes);
    localparam int CntW = $clog2(MaxNodes + 1);

    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_EVAL   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DUP = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] node_x;
        logic signed [31:0] node_y;
        logic signed [31:0] query_point;
    } t_in;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_out;

    // Saturate a 64-bit value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic ovf32(input logic signed [63:0] v);
        return (v > 64'sh7FFF_FFFF) || (v < -64'sh8000_0000);
    endfunction
endpackage
`default_nettype wire

FILE: hdl/ndd_if.sv
// Valid/ready channel carrying one beat of payload.
// Depends on nothing; payload type given by parameter.
`default_nettype none
interface ndd_if #(parameter type T = logic) (input wire logic i_clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/newton_divided_difference_interp.sv
// Newton divided-difference interpolator: up to ndd_pkg::MaxNodes nodes in
// signed Q16.16. Append (action 0) stores a node, clear (2) empties the store,
// evaluate (1) checks abscissas pairwise, builds the divided-difference table
// in place with one shared serial divider, then runs the Newton sum with one
// 32x32 multiplier. One item at a time; ready is low while busy. A result
// beat waits in an output register; ready stays low until it is taken.
`default_nettype none
module newton_divided_difference_interp (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ndd_if.sink      i_in,
    ndd_if.source    o_out
);
    import ndd_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DUP  = 9'b000000010,
        S_COPY = 9'b000000100,
        S_DRD  = 9'b000001000,
        S_DGO  = 9'b000010000,
        S_DWT  = 9'b000100000,
        S_EM1  = 9'b001000000,
        S_EM2  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_st;
    // node stores and the working table: flip-flop arrays, read at indexes
    logic signed [31:0] r_x [MaxNodes];
    logic signed [31:0] r_y [MaxNodes];
    logic signed [31:0] r_d [MaxNodes];
    logic [CntW-1:0]    r_n;
    logic [CntW-1:0]    r_i, r_j, r_k;
    logic signed [31:0] r_q, r_p;
    logic signed [63:0] r_sum;
    logic signed [63:0] r_prod;
    logic               r_ovf;
    logic signed [48:0] r_num;
    logic signed [32:0] r_den;
    logic               w_dstart, w_ddone;
    logic signed [48:0] w_quot;
    logic signed [32:0] w_t;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_mul;
    logic signed [63:0] w_pq;

    ndd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(r_num), .i_den(r_den), .o_done(w_ddone), .o_quot(w_quot)
    );
    assign w_dstart = (r_st == S_DGO);
    assign i_in.ready = (r_st == S_IDLE) && !o_out.valid;
    assign w_t = 33'(r_q) - 33'(r_x[r_i[IdxW-1:0]]);

    // shared multiplier: p * c_i in S_EM1, p * t in S_EM2
    assign w_mb  = (r_st == S_EM1) ? r_d[r_i[IdxW-1:0]] : sat32(64'(w_t));
    assign w_mul = r_p * w_mb;
    // (p * t) / 65536, truncated toward zero
    assign w_pq  = (w_mul + (w_mul[63] ? 64'sd65535 : 64'sd0)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_n         <= '0;
            o_out.valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) o_out.valid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    case (i_in.data.action)
                        ACT_APPEND: if (r_n < CntW'(MaxNodes)) begin
                            r_x[r_n[IdxW-1:0]] <= i_in.data.node_x;
                            r_y[r_n[IdxW-1:0]] <= i_in.data.node_y;
                            r_n <= r_n + 1'b1;
                        end
                        ACT_CLEAR: r_n <= '0;
                        ACT_EVAL: begin
                            r_q   <= i_in.data.query_point;
                            r_ovf <= 1'b0;
                            r_i   <= '0;
                            r_j   <= CntW'(1);
                            r_st  <= S_DUP;
                        end
                        default: ;
                    endcase
                end
                S_DUP: begin
                    // pairwise scan i < j
                    if (r_i + 1'b1 >= r_n || r_n == '0) begin
                        r_i  <= '0;
                        r_st <= S_COPY;
                    end else if (r_x[r_i[IdxW-1:0]] == r_x[r_j[IdxW-1:0]]) begin
                        o_out.data.value  <= '0;
                        o_out.data.status <= ST_DUP;
                        r_st <= S_OUT;
                    end else if (r_j + 1'b1 >= r_n) begin
                        r_i <= r_i + 1'b1;
                        r_j <= r_i + 2'd2;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_COPY: begin
                    if (r_i >= r_n) begin
                        r_k  <= CntW'(1);
                        r_j  <= r_n - 1'b1;
                        r_st <= S_DRD;
                    end else begin
                        r_d[r_i[IdxW-1:0]] <= r_y[r_i[IdxW-1:0]];
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DRD: begin
                    if (r_k >= r_n) begin
                        r_i     <= '0;
                        r_p     <= 32'sd65536;
                        r_sum   <= '0;
                        r_st    <= (r_n == '0) ? S_OUT : S_EM1;
                        o_out.data.value  <= '0;
                        o_out.data.status <= ST_OK;
                    end else if (r_j < r_k) begin
                        r_k <= r_k + 1'b1;
                        r_j <= r_n - 1'b1;
                    end else begin
                        r_num <= 49'(33'(r_d[r_j[IdxW-1:0]])
                                 - 33'(r_d[r_j[IdxW-1:0] - 1'b1])) <<< 16;
                        r_den <= 33'(r_x[r_j[IdxW-1:0]])
                                 - 33'(r_x[IdxW'(r_j - r_k)]);
                        r_st  <= S_DGO;
                    end
                end
                S_DGO: r_st <= S_DWT;
                S_DWT: if (w_ddone) begin
                    r_d[r_j[IdxW-1:0]] <= sat32(64'(w_quot));
                    if (ovf32(64'(w_quot))) r_ovf <= 1'b1;
                    r_j  <= r_j - 1'b1;
                    r_st <= S_DRD;
                end
                S_EM1: begin
                    // product for sum += (p * c_i) / 65536
                    r_prod <= w_mul;
                    r_st   <= S_EM2;
                end
                S_EM2: begin
                    if (r_i + 1'b1 < r_n) begin
                        r_sum <= r_sum
                                 + ((r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0)) >>> 16);
                        if (ovf32(64'(w_t)) || ovf32(w_pq)) r_ovf <= 1'b1;
                        r_p   <= sat32(w_pq);
                        r_i   <= r_i + 1'b1;
                        r_st  <= S_EM1;
                    end else begin
                        logic signed [63:0] s;
                        s = r_sum + ((r_prod + (r_prod[63] ? 64'sd65535 : 64'sd0)) >>> 16);
                        o_out.data.value  <= sat32(s);
                        o_out.data.status <= (r_ovf || ovf32(s)) ? ST_SAT : ST_OK;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_out.valid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/ndd_div.sv
// Radix-2 restoring divider, signed, quotient truncated toward zero.
// Dividend up to 49 bits, divisor 33 bits. Uses ndd_pkg.
`default_nettype none
module ndd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [48:0] i_num,
    input  wire logic signed [32:0] i_den,
    output logic                    o_done,
    output logic signed [48:0]      o_quot
);
    import ndd_pkg::*;
    logic [48:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_d;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_sh;
    logic [34:0] w_sub;

    assign w_sh  = {r_rem[32:0], r_q[48]};
    assign w_sub = {1'b0, w_sh} - {2'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd49;
                r_q    <= i_num[48] ? 49'(-i_num) : i_num;
                r_d    <= i_den[32] ? 33'(-i_den) : i_den;
                r_neg  <= i_num[48] ^ i_den[32];
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_sub[34]) begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[47:0], 1'b0};
                end else begin
                    r_rem <= w_sub[33:0];
                    r_q   <= {r_q[47:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_neg ? 49'(-r_q) : r_q;
endmodule
`default_nettype wire
